// ===== hw/rtl/utf8d_pkg.sv =====
package utf8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int REMAIN_W    = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int KIND_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CP       = 2'd0,
        KIND_PARTIAL  = 2'd1,
        KIND_BAD_LEAD = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        t_kind           kind;
        logic            is_last;
    } t_result;

endpackage

// ===== hw/rtl/utf8d_decode.sv =====
module utf8d_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [utf8d_pkg::BYTE_W-1:0]  i_byte,
    input  logic                          i_last,
    output logic                          o_res_valid,
    output utf8d_pkg::t_result            o_res
);

    logic [utf8d_pkg::CP_W-1:0]     r_pend;
    logic [utf8d_pkg::CP_W-1:0]     n_pend;
    logic [utf8d_pkg::REMAIN_W-1:0] r_remain;
    logic [utf8d_pkg::REMAIN_W-1:0] n_remain;
    logic                           r_discard;
    logic                           n_discard;
    logic [utf8d_pkg::CP_W-1:0]     w_shifted;
    logic [utf8d_pkg::REMAIN_W-1:0] w_remain_dec;

    assign w_shifted    = {r_pend[utf8d_pkg::CP_W-7:0], i_byte[5:0]};
    assign w_remain_dec = r_remain - utf8d_pkg::REMAIN_W'(1);

    always_comb begin
        n_pend           = r_pend;
        n_remain         = r_remain;
        n_discard        = r_discard;
        o_res_valid      = 1'b0;
        o_res.code_point = '0;
        o_res.kind       = utf8d_pkg::KIND_CP;
        o_res.is_last    = i_last;
        if (r_discard) begin
            if (i_last) begin
                n_discard = 1'b0;
            end
        end else if (r_remain != '0) begin
            n_remain = w_remain_dec;
            n_pend   = w_shifted;
            if (w_remain_dec == '0) begin
                o_res_valid      = 1'b1;
                o_res.code_point = w_shifted;
                n_pend           = '0;
            end else if (i_last) begin
                o_res_valid   = 1'b1;
                o_res.kind    = utf8d_pkg::KIND_PARTIAL;
                o_res.is_last = 1'b1;
                n_pend        = '0;
                n_remain      = '0;
            end
        end else begin
            if (i_byte inside {[8'h00:8'h7F]}) begin
                o_res_valid      = 1'b1;
                o_res.code_point = utf8d_pkg::CP_W'(i_byte);
            end else if (i_byte inside {[8'hC0:8'hDF]}) begin
                n_pend   = utf8d_pkg::CP_W'(i_byte[4:0]);
                n_remain = utf8d_pkg::REMAIN_W'(1);
            end else if (i_byte inside {[8'hE0:8'hEF]}) begin
                n_pend   = utf8d_pkg::CP_W'(i_byte[3:0]);
                n_remain = utf8d_pkg::REMAIN_W'(2);
            end else if (i_byte inside {[8'hF0:8'hF7]}) begin
                n_pend   = utf8d_pkg::CP_W'(i_byte[2:0]);
                n_remain = utf8d_pkg::REMAIN_W'(3);
            end else begin
                o_res_valid   = 1'b1;
                o_res.kind    = utf8d_pkg::KIND_BAD_LEAD;
                o_res.is_last = 1'b1;
                n_discard     = !i_last;
            end
            if (i_last && (n_remain != '0)) begin
                o_res_valid   = 1'b1;
                o_res.kind    = utf8d_pkg::KIND_PARTIAL;
                o_res.is_last = 1'b1;
                n_pend        = '0;
                n_remain      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_remain  <= '0;
            r_discard <= 1'b0;
        end else if (i_fire) begin
            r_pend    <= n_pend;
            r_remain  <= n_remain;
            r_discard <= n_discard;
        end
    end

    a_discard_no_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_remain == '0))
        else $error("discard set with an open sequence");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last) |=> ((r_remain == '0) && !r_discard))
        else $error("last byte left decoder state open");

    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind != utf8d_pkg::KIND_CP))
            |-> ((o_res.code_point == '0) && o_res.is_last))
        else $error("error result with nonzero code point or not last");

    a_no_result_in_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> !o_res_valid)
        else $error("result produced while dropping");

endmodule

// ===== hw/rtl/utf8_to_code_point_decoder_top.sv =====
// Channel  | Direction | tdata                      | tuser        | tlast
// s_axis   | in        | [7:0] in_byte              | -            | last_byte
// m_axis   | out       | [20:0] code_point, zero pad| [1:0] kind   | is_last
//
// One byte item per clock while the result register is not stalled; a result is registered.
// The rate is set by the combinational decode step between the input and result registers.
// Reset (synchronous, i_rst_n low) empties both registers and returns to lead-byte state.
// A stalled result holds in its register; an input item is still taken while the result
// register drains in the same cycle. Items that give no result leave the output untouched.
module utf8_to_code_point_decoder_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [utf8d_pkg::BYTE_W-1:0]          i_s_axis_tdata,   // [7:0] in_byte
    input  logic                                  i_s_axis_tlast,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [utf8d_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,   // [20:0] code_point
    output logic [utf8d_pkg::KIND_W-1:0]          o_m_axis_tuser,   // [1:0] kind
    output logic                                  o_m_axis_tlast
);

    logic                          r_in_valid;
    logic [utf8d_pkg::BYTE_W-1:0]  r_in_byte;
    logic                          r_in_last;
    logic                          r_out_valid;
    utf8d_pkg::t_result            r_out_res;
    logic                          w_adv;
    logic                          w_res_valid;
    utf8d_pkg::t_result            w_res;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    utf8d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_adv),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_valid) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(utf8d_pkg::OUT_TDATA_W-utf8d_pkg::CP_W){1'b0}},
                              r_out_res.code_point};
    assign o_m_axis_tuser  = r_out_res.kind;
    assign o_m_axis_tlast  = r_out_res.is_last;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES = 1400;

    class cp_predictor;
        logic [utf8d_pkg::CP_W-1:0]     acc;
        logic [utf8d_pkg::REMAIN_W-1:0] left;
        bit                             dropping;
        utf8d_pkg::t_result             want_q[$];
        int                             errors;
        int                             n_cp;
        int                             n_partial;
        int                             n_bad;
        int                             n_seen;

        function new();
            acc = '0;
            left = '0;
            dropping = 1'b0;
            errors = 0;
            n_cp = 0;
            n_partial = 0;
            n_bad = 0;
            n_seen = 0;
        endfunction

        function void post(logic [utf8d_pkg::CP_W-1:0] cp, utf8d_pkg::t_kind k, logic l);
            utf8d_pkg::t_result r;
            r.code_point = cp;
            r.kind = k;
            r.is_last = l;
            want_q.push_back(r);
            case (k)
                utf8d_pkg::KIND_CP:      n_cp++;
                utf8d_pkg::KIND_PARTIAL: n_partial++;
                default:                 n_bad++;
            endcase
        endfunction

        function void take_byte(logic [utf8d_pkg::BYTE_W-1:0] b, logic last);
            if (dropping) begin
                if (last) dropping = 1'b0;
                return;
            end
            if (left != 0) begin
                acc = {acc[utf8d_pkg::CP_W-7:0], b[5:0]};
                left = left - 1'b1;
                if (left == 0) begin
                    post(acc, utf8d_pkg::KIND_CP, last);
                    acc = '0;
                end else if (last) begin
                    acc = '0;
                    left = '0;
                    post('0, utf8d_pkg::KIND_PARTIAL, 1'b1);
                end
                return;
            end
            if (!b[7]) begin
                post({{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, b}, utf8d_pkg::KIND_CP,
                     last);
                return;
            end
            if (b[7:5] == 3'b110) begin
                acc = {{(utf8d_pkg::CP_W-5){1'b0}}, b[4:0]};
                left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                acc = {{(utf8d_pkg::CP_W-4){1'b0}}, b[3:0]};
                left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                acc = {{(utf8d_pkg::CP_W-3){1'b0}}, b[2:0]};
                left = 2'd3;
            end else begin
                if (!last) dropping = 1'b1;
                post('0, utf8d_pkg::KIND_BAD_LEAD, 1'b1);
                return;
            end
            if (last) begin
                acc = '0;
                left = '0;
                post('0, utf8d_pkg::KIND_PARTIAL, 1'b1);
            end
        endfunction

        function void match_result(logic [utf8d_pkg::OUT_TDATA_W-1:0] data,
                                   logic [utf8d_pkg::KIND_W-1:0] kind, logic last);
            utf8d_pkg::t_result w;
            n_seen++;
            if (want_q.size() == 0) begin
                $error("unexpected result: code_point=%0h kind=%0d is_last=%b",
                       data[utf8d_pkg::CP_W-1:0], kind, last);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (data[utf8d_pkg::CP_W-1:0] !== w.code_point) begin
                $error("code_point: expected %0h, actual %0h", w.code_point,
                       data[utf8d_pkg::CP_W-1:0]);
                errors++;
            end
            if (data[utf8d_pkg::OUT_TDATA_W-1:utf8d_pkg::CP_W] !== '0) begin
                $error("tdata pad: expected 0, actual %0h",
                       data[utf8d_pkg::OUT_TDATA_W-1:utf8d_pkg::CP_W]);
                errors++;
            end
            if (kind !== w.kind) begin
                $error("kind: expected %0d, actual %0d", w.kind, kind);
                errors++;
            end
            if (last !== w.is_last) begin
                $error("is_last: expected %b, actual %b", w.is_last, last);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_valid = 1'b0;
    logic [utf8d_pkg::BYTE_W-1:0]        s_data = '0;
    logic                                s_last = 1'b0;
    logic                                m_ready = 1'b0;
    logic                                s_ready;
    logic                                m_valid;
    logic [utf8d_pkg::OUT_TDATA_W-1:0]   m_data;
    logic [utf8d_pkg::KIND_W-1:0]        m_user;
    logic                                m_last;

    cp_predictor decoder_model = new();
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    int  bytes_in = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    utf8_to_code_point_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] in_byte
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [20:0] code_point, [23:21] zero
        .o_m_axis_tuser  (m_user),   // [1:0] kind
        .o_m_axis_tlast  (m_last)
    );

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic send_byte(input logic [utf8d_pkg::BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        s_last <= last;
        do @(posedge i_clk); while (!s_ready);
        decoder_model.take_byte(b, last);
        bytes_in++;
    endtask

    function automatic logic [utf8d_pkg::BYTE_W-1:0] tail_byte();
        if ($urandom_range(0, 9) == 0) return utf8d_pkg::BYTE_W'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic append_char(ref logic [utf8d_pkg::BYTE_W-1:0] chunk[$], input int len,
                               input int cut);
        case (len)
            2:       chunk.push_back({3'b110, 5'($urandom_range(0, 31))});
            3:       chunk.push_back({4'b1110, 4'($urandom_range(0, 15))});
            default: chunk.push_back({5'b11110, 3'($urandom_range(0, 7))});
        endcase
        for (int i = 1; i < len - cut; i++) chunk.push_back(tail_byte());
    endtask

    task automatic send_chunk(ref logic [utf8d_pkg::BYTE_W-1:0] chunk[$]);
        foreach (chunk[i]) send_byte(chunk[i], i == chunk.size() - 1);
    endtask

    initial begin : drain
        int stall;
        int hold;
        stall = 0;
        hold = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_valid && m_ready) decoder_model.match_result(m_data, m_user, m_last);
            if (hold_req) begin
                hold = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [8:0]                   opening[$];
        logic [utf8d_pkg::BYTE_W-1:0] chunk[$];
        bit                           pressed;
        int                           n_chars;
        int                           r;
        pressed = 1'b0;
        // bit 8 marks the last byte of a buffer
        opening = '{9'h000, 9'h17F,
                    9'h0C2, 9'h1A9, 9'h0C2, 9'h0A9,
                    9'h0E2, 9'h082, 9'h0AC,
                    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
                    9'h0C3, 9'h141,
                    9'h080, 9'h041, 9'h1FF,
                    9'h1FF,
                    9'h1E2,
                    9'h0F0, 9'h19F,
                    9'h0F8, 9'h100};
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        calm = 1'b1;
        foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);
        while (bytes_in < RANDOM_BYTES + opening.size()) begin
            calm = ($urandom_range(0, 4) == 0);
            if (!pressed && bytes_in > 500) begin
                calm = 1'b1;
                hold_req = 1'b1;
                pressed = 1'b1;
            end
            chunk.delete();
            n_chars = $urandom_range(1, 8);
            for (int c = 0; c < n_chars; c++) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    chunk.push_back({1'b0, 7'($urandom_range(0, 127))});
                end else if (r < 55) begin
                    append_char(chunk, 2, 0);
                end else if (r < 72) begin
                    append_char(chunk, 3, 0);
                end else if (r < 85) begin
                    append_char(chunk, 4, 0);
                end else if (r < 90) begin
                    chunk.push_back(utf8d_pkg::BYTE_W'($urandom_range(0, 255)));
                end else if (r < 95) begin
                    if ($urandom_range(0, 1) == 0)
                        chunk.push_back({2'b10, 6'($urandom_range(0, 63))});
                    else
                        chunk.push_back({5'b11111, 3'($urandom_range(0, 7))});
                end else begin
                    r = $urandom_range(2, 4);
                    append_char(chunk, r, $urandom_range(1, r - 1));
                    break;
                end
            end
            send_chunk(chunk);
        end
        s_valid <= 1'b0;
        while (decoder_model.want_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Fed %0d bytes in directed and random buffers, under stalls on both sides.",
                 bytes_in);
        $display("Checked %0d results: %0d code points, %0d cut-short buffers, %0d bad leads.",
                 decoder_model.n_seen, decoder_model.n_cp, decoder_model.n_partial,
                 decoder_model.n_bad);
        if (decoder_model.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_decode.sv
hw/rtl/utf8_to_code_point_decoder_top.sv
dv/tb_top.sv
